// File: design/uhc_pkg.sv
// uhc_pkg: shared types, codes and constants of the ipv4/udp header checker
// no dependencies; imported by uhc_front, uhc_back and ipv4_udp_header_check
package uhc_pkg;

    // link kinds
    localparam logic [2:0] LINK_LOOP = 3'd0;
    localparam logic [2:0] LINK_ETH  = 3'd1;
    localparam logic [2:0] LINK_SLIP = 3'd2;
    localparam logic [2:0] LINK_PPP  = 3'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ETHTYPE  = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_HDR_LEN  = 3'd4;
    localparam logic [2:0] ST_CHECKSUM = 3'd5;
    localparam logic [2:0] ST_NOT_UDP  = 3'd6;
    localparam logic [2:0] ST_LINK     = 3'd7;

    // register indexes
    localparam logic [0:0] REG_LINK_KIND = 1'b0;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam int unsigned IP_MIN_HDR     = 20;
    localparam int unsigned UDP_HDR        = 8;
    localparam int unsigned ETH_HDR        = 14;
    localparam int unsigned ETH_TYPE_HI    = 12;
    localparam int unsigned ETH_TYPE_LO    = 13;
    localparam int unsigned IP_PROTO_OFF   = 9;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] kind;
        logic       eth_hit;   // byte is one of the ethertype bytes
        logic       in_ip;     // byte lies past the link header
        logic       off_small; // offset into ip part below 64
        logic [5:0] off;       // low bits of that offset
    } t_cls;

    // link header length, 0 for unsupported kinds
    function automatic logic [4:0] link_len(input logic [2:0] kind);
        logic [4:0] len;
        unique case (kind)
            LINK_LOOP: len = 5'd4;
            LINK_ETH:  len = 5'd14;
            LINK_SLIP: len = 5'd24;
            LINK_PPP:  len = 5'd24;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: design/uhc_front.sv
// uhc_front: accepts frame bytes, counts them and classifies each byte
// depends on uhc_pkg; feeds uhc_fifo
module uhc_front
    import uhc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data,
    input  logic                   i_last,
    input  logic [2:0]             i_kind,
    input  logic                   i_full,
    output logic                   o_ready,
    output logic                   o_push,
    output t_cls                   o_cls,
    output logic [LENGTH_BITS-1:0] o_count
);

    logic [LENGTH_BITS-1:0] r_idx;
    logic [LENGTH_BITS-1:0] n_idx;
    logic [LENGTH_BITS-1:0] llen;
    logic [LENGTH_BITS-1:0] off;
    logic                   in_ip;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        llen  = LENGTH_BITS'(link_len(i_kind));
        in_ip = (llen != '0) && (r_idx >= llen);
        off   = r_idx - llen;

        o_cls.data      = i_data;
        o_cls.last      = i_last;
        o_cls.kind      = i_kind;
        o_cls.eth_hit   = (i_kind == LINK_ETH) &&
                          ((r_idx == LENGTH_BITS'(ETH_TYPE_HI)) ||
                           (r_idx == LENGTH_BITS'(ETH_TYPE_LO)));
        o_cls.in_ip     = in_ip;
        o_cls.off_small = off < LENGTH_BITS'(64);
        o_cls.off       = off[5:0];

        // saturating byte count including this byte
        o_count = (r_idx == '1) ? r_idx : r_idx + LENGTH_BITS'(1);
        n_idx   = i_last ? '0 : o_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            r_idx <= n_idx;
        end
    end

endmodule

// File: design/uhc_fifo.sv
// uhc_fifo: two-entry queue between the classifying front and the checking back
// no dependencies
module uhc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: design/uhc_back.sv
// uhc_back: header field capture, ones-complement sum and verdict per frame
// depends on uhc_pkg; drains uhc_fifo and holds the result register
module uhc_back
    import uhc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_cls                   i_cls,
    input  logic [LENGTH_BITS-1:0] i_count,
    input  logic                   i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [2:0]             o_status,
    output logic [5:0]             o_header_bytes,
    output logic [15:0]            o_ip_bytes
);

    localparam int IW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic [15:0] r_eth;
    logic [3:0]  r_ver;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [16:0] r_sum;
    logic [7:0]  r_hold;
    logic        r_valid;
    logic [2:0]  r_status;
    logic [5:0]  r_hbytes;
    logic [15:0] r_ipbytes;

    logic [15:0] n_eth;
    logic [3:0]  n_ver;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [16:0] n_sum;
    logic [7:0]  n_hold;
    logic [2:0]  n_status;
    logic [5:0]  n_hbytes;
    logic [15:0] n_ipbytes;

    logic                   at0;
    logic                   at_proto;
    logic                   hdr_byte;
    logic [17:0]            sum_raw;
    logic [LENGTH_BITS-1:0] llen;
    logic [LENGTH_BITS-1:0] ipb;
    logic [LENGTH_BITS-1:0] hlen_w;
    logic [IW-1:0]          ipb_w;
    logic [6:0]             hlen;

    assign o_pop          = i_valid && (!i_cls.last || !r_valid || i_ready);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_header_bytes = r_hbytes;
    assign o_ip_bytes     = r_ipbytes;

    always_comb begin
        at0      = i_cls.in_ip && i_cls.off_small && (i_cls.off == 6'd0);
        at_proto = i_cls.in_ip && i_cls.off_small && (i_cls.off == 6'(IP_PROTO_OFF));

        n_eth   = i_cls.eth_hit ? {r_eth[7:0], i_cls.data} : r_eth;
        n_ver   = at0 ? i_cls.data[7:4] : r_ver;
        n_ihl   = at0 ? i_cls.data[3:0] : r_ihl;
        n_proto = at_proto ? i_cls.data : r_proto;

        // header bytes pair up into words; end-around carry folded back
        hdr_byte = i_cls.in_ip && i_cls.off_small && (i_cls.off < {n_ihl, 2'b00});
        sum_raw  = {1'b0, r_sum} + {2'b00, r_hold, i_cls.data};
        n_hold   = (hdr_byte && !i_cls.off[0]) ? i_cls.data : r_hold;
        n_sum    = (hdr_byte && i_cls.off[0]) ?
                   17'(sum_raw[15:0]) + 17'(sum_raw[17:16]) : r_sum;

        // verdict, valid only on the last byte
        llen   = LENGTH_BITS'(link_len(i_cls.kind));
        ipb    = ((llen != '0) && (i_count > llen)) ? i_count - llen : '0;
        hlen   = {1'b0, n_ihl, 2'b00};
        hlen_w = LENGTH_BITS'(hlen);

        if (llen == '0) begin
            n_status = ST_LINK;
        end else if ((i_cls.kind == LINK_ETH) && (i_count < LENGTH_BITS'(ETH_HDR))) begin
            n_status = ST_SHORT;
        end else if ((i_cls.kind == LINK_ETH) && (n_eth != ETHERTYPE_IPV4)) begin
            n_status = ST_ETHTYPE;
        end else if (ipb < LENGTH_BITS'(IP_MIN_HDR + UDP_HDR)) begin
            n_status = ST_SHORT;
        end else if (n_ver != IP_VERSION) begin
            n_status = ST_VERSION;
        end else if (hlen < 7'(IP_MIN_HDR)) begin
            n_status = ST_HDR_LEN;
        end else if (ipb < hlen_w + LENGTH_BITS'(UDP_HDR)) begin
            n_status = ST_SHORT;
        end else if (n_sum != 17'h0FFFF) begin
            n_status = ST_CHECKSUM;
        end else if (n_proto != PROTO_UDP) begin
            n_status = ST_NOT_UDP;
        end else begin
            n_status = ST_OK;
        end

        ipb_w     = IW'(ipb);
        n_hbytes  = (llen == '0) ? 6'd0 : hlen[5:0];
        n_ipbytes = (ipb_w > IW'(16'hFFFF)) ? 16'hFFFF : ipb_w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eth   <= '0;
            r_ver   <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_cls.last) begin
                    r_eth   <= '0;
                    r_ver   <= '0;
                    r_ihl   <= '0;
                    r_proto <= '0;
                    r_sum   <= '0;
                    r_hold  <= '0;
                end else begin
                    r_eth   <= n_eth;
                    r_ver   <= n_ver;
                    r_ihl   <= n_ihl;
                    r_proto <= n_proto;
                    r_sum   <= n_sum;
                    r_hold  <= n_hold;
                end
            end
            if (o_pop && i_cls.last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_status  <= n_status;
            r_hbytes  <= n_hbytes;
            r_ipbytes <= n_ipbytes;
        end
    end

endmodule

// File: design/ipv4_udp_header_check.sv
// ipv4_udp_header_check: top level with the config register and the assertions
// depends on uhc_pkg, uhc_front, uhc_fifo and uhc_back
//
// Frame bytes enter on the s_axis channel, one byte per word, with tlast on
// the final byte of a frame. The link header is skipped by the link kind in
// register 0 (loopback, ethernet, slip or ppp), then the IPv4 header is
// checked: version, header length, length, checksum and UDP protocol.
// For each frame one status word leaves on m_axis after its last byte.
// The front counts and classifies each byte, a two-entry queue decouples it
// from the back, which adds header words into the ones-complement sum
// and forms the verdict. Throughput is one byte per cycle while m_axis does
// not stall; the back registers the status word when it takes the last byte.
// When m_axis stalls, the result is held and bytes keep flowing until the
// next frame's last byte reaches the back and the queue fills.
// Reset (synchronous, active low) sets link kind to ethernet and clears the frame
// state; the user must write the register over APB only while no frame is in flight;
// the block does not enforce this. LENGTH_BITS sets the saturating byte counter width.
module ipv4_udp_header_check
    import uhc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // frame bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
    input  logic        s_axis_tlast,  // frame_end
    // status
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [2:0] status, [8:3] header_bytes, [24:9] ip_bytes
);

    localparam int QW = $bits(t_cls) + LENGTH_BITS;

    logic [2:0]             r_link_kind;
    logic                   push;
    logic                   full;
    logic                   q_valid;
    logic                   pop;
    t_cls                   f_cls;
    t_cls                   q_cls;
    logic [LENGTH_BITS-1:0] f_count;
    logic [LENGTH_BITS-1:0] q_count;
    logic [QW-1:0]          q_data;
    logic [2:0]             status;
    logic [5:0]             header_bytes;
    logic [15:0]            ip_bytes;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINK_KIND) ? {29'd0, r_link_kind} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind <= LINK_ETH;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LINK_KIND)) begin
            r_link_kind <= pwdata[2:0];
        end
    end

    uhc_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_kind  (r_link_kind),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_cls   (f_cls),
        .o_count (f_count)
    );

    uhc_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cls, f_count}),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_cls   = t_cls'(q_data[QW-1:LENGTH_BITS]);
    assign q_count = q_data[LENGTH_BITS-1:0];

    uhc_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_cls          (q_cls),
        .i_count        (q_count),
        .i_ready        (m_axis_tready),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .o_status       (status),
        .o_header_bytes (header_bytes),
        .o_ip_bytes     (ip_bytes)
    );

    assign m_axis_tdata = {7'd0, ip_bytes, header_bytes, status};

`ifndef SYNTHESIS
    // a new result only appears after the back took a last byte
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(pop && q_cls.last))
        else $error("result without a last byte");

    a_link_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == ST_LINK)) |-> (header_bytes == 6'd0 && ip_bytes == 16'd0))
        else $error("unsupported link with nonzero lengths");

    a_ok_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == ST_OK)) |->
        (header_bytes >= 6'd20 && {1'b0, ip_bytes} >= {11'd0, header_bytes} + 17'd8))
        else $error("udp ok with short lengths");
`endif

endmodule
